[hdl/hrq_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the ring queue.
`timescale 1ns / 1ps

package hrq_pkg;

   localparam int HRQ_DEPTH_DEFAULT = 64;
   localparam int ADDR_W            = 64;
   localparam int SLOT_W            = 6;
   localparam int INDEX_W           = 6;

   // request modes
   localparam logic [1:0] MODE_LOOKUP = 2'd0;
   localparam logic [1:0] MODE_ADD    = 2'd1;
   localparam logic [1:0] MODE_REMOVE = 2'd2;

   // response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_MISS  = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   typedef enum logic [2:0] {
      S_CLEAR = 3'b001,
      S_IDLE  = 3'b010,
      S_SCAN  = 3'b100
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       clear_step;
      logic       load;
      logic       scan_free;
      logic       scan_step;
      logic       commit_add;
      logic       commit_remove;
      logic       respond;
      logic       resp_hit;
      logic [1:0] resp_status;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic lookup_empty;
      logic add_blocked;
      logic remove_empty;
      logic slot_ok;
      logic scan_hit;
      logic scan_done;
   } sts_type;

endpackage

[hdl/hrq_ctrl.sv]
// Sequencer for the ring queue: clearing pass, request decode and scan control.
`timescale 1ns / 1ps

module hrq_ctrl import hrq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_mode,
   input  sts_type    sts,
   output cmd_type    cmd,
   output logic       busy
);

   state_type state_ff, state_in;
   logic      op_add_ff, op_add_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      op_add_in = op_add_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               unique case (req_mode)
                  MODE_LOOKUP: begin
                     if (sts.lookup_empty) begin
                        cmd.respond     = 1'b1;
                        cmd.resp_status = ST_MISS;
                     end else begin
                        cmd.load  = 1'b1;
                        op_add_in = 1'b0;
                        state_in  = S_SCAN;
                     end
                  end
                  MODE_ADD: begin
                     if (sts.add_blocked) begin
                        cmd.respond     = 1'b1;
                        cmd.resp_status = ST_FULL;
                     end else begin
                        cmd.load      = 1'b1;
                        cmd.scan_free = 1'b1;
                        op_add_in     = 1'b1;
                        state_in      = S_SCAN;
                     end
                  end
                  MODE_REMOVE: begin
                     cmd.respond = 1'b1;
                     if (sts.remove_empty) begin
                        cmd.resp_status = ST_EMPTY;
                     end else if (sts.slot_ok) begin
                        cmd.commit_remove = 1'b1;
                        cmd.resp_status   = ST_OK;
                     end else begin
                        cmd.resp_status = ST_MISS;
                     end
                  end
                  default: begin
                     cmd.respond     = 1'b1;
                     cmd.resp_status = ST_MISS;
                  end
               endcase
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_hit) begin
               cmd.respond     = 1'b1;
               cmd.resp_hit    = 1'b1;
               cmd.resp_status = ST_OK;
               cmd.commit_add  = op_add_ff;
               state_in        = S_IDLE;
            end else if (sts.scan_done) begin
               cmd.respond     = 1'b1;
               cmd.resp_status = op_add_ff ? ST_FULL : ST_MISS;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         op_add_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         op_add_ff <= op_add_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

[hdl/hrq_dpath.sv]
// Datapath for the ring queue: slot memory, pointers, occupancy, scan pipeline, response regs.
`timescale 1ns / 1ps

module hrq_dpath import hrq_pkg::*; #(
   parameter int QUEUE_DEPTH = HRQ_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   input  logic [ADDR_W-1:0]   req_block_addr,
   input  logic [ADDR_W-1:0]   req_byte_addr,
   input  logic [SLOT_W-1:0]   req_slot,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [INDEX_W-1:0]  rsp_index
);

   localparam int PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W     = PTR_W + SLOT_W;
   localparam int IDX_EXT_W = PTR_W + INDEX_W;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] s);
      if (s == LAST_SLOT) begin
         return '0;
      end
      return s + 1'b1;
   endfunction

   // slot memory: {block_addr, byte_addr}
   logic [2*ADDR_W-1:0] mem [QUEUE_DEPTH];

   logic [PTR_W-1:0]    head_ff, tail_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                mfa_ff;
   logic [PTR_W-1:0]    issue_addr_ff;
   logic [CNT_W-1:0]    left_ff;
   logic                pend_valid_ff;
   logic [PTR_W-1:0]    pend_addr_ff;
   logic [2*ADDR_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]   blk_ff, full_ff;
   logic                scan_free_ff;
   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff;
   logic [INDEX_W-1:0]  rsp_index_ff;

   logic [CMP_W-1:0]     slot_ext;
   logic [PTR_W-1:0]     slot_addr;
   logic [CNT_W-1:0]     lookup_len;
   logic [ADDR_W-1:0]    rd_blk, rd_full;
   logic                 match;
   logic                 mem_we;
   logic [PTR_W-1:0]     mem_waddr;
   logic [2*ADDR_W-1:0]  mem_wdata;
   logic [IDX_EXT_W-1:0] hit_ext;

   assign slot_ext  = CMP_W'(req_slot);
   assign slot_addr = slot_ext[PTR_W-1:0];
   assign hit_ext   = IDX_EXT_W'(pend_addr_ff);

   // occupied span from head toward tail, wrapping; a full ring when the pointers meet
   always_comb begin
      if (head_ff < tail_ff) begin
         lookup_len = CNT_W'(tail_ff - head_ff);
      end else begin
         lookup_len = DEPTH_CNT - CNT_W'(head_ff) + CNT_W'(tail_ff);
      end
   end

   assign rd_blk  = rd_data_ff[2*ADDR_W-1:ADDR_W];
   assign rd_full = rd_data_ff[ADDR_W-1:0];

   always_comb begin
      if (scan_free_ff) begin
         match = (rd_blk == '0);
      end else if (mfa_ff) begin
         match = (rd_full == full_ff);
      end else begin
         match = (rd_blk == blk_ff);
      end
   end

   always_comb begin
      mem_we    = cmd.clear_step | cmd.commit_remove | cmd.commit_add;
      mem_wdata = cmd.commit_add ? {blk_ff, full_ff} : '0;
      if (cmd.clear_step) begin
         mem_waddr = issue_addr_ff;
      end else if (cmd.commit_remove) begin
         mem_waddr = slot_addr;
      end else begin
         mem_waddr = pend_addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[issue_addr_ff];
   end

   always_comb begin
      sts.clear_last   = (issue_addr_ff == LAST_SLOT);
      sts.lookup_empty = (count_ff == '0) && (head_ff == tail_ff);
      sts.add_blocked  = ((count_ff != '0) && (head_ff == tail_ff)) || (count_ff >= DEPTH_CNT);
      sts.remove_empty = (count_ff == '0);
      sts.slot_ok      = (slot_ext < CMP_W'(QUEUE_DEPTH));
      sts.scan_hit     = pend_valid_ff && match;
      sts.scan_done    = !pend_valid_ff && (left_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         mfa_ff        <= 1'b0;
         issue_addr_ff <= '0;
         left_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
         if (csr_wr_en) begin
            mfa_ff <= csr_wr_data;
         end
         if (cmd.clear_step) begin
            issue_addr_ff <= next_slot(issue_addr_ff);
         end else if (cmd.load) begin
            issue_addr_ff <= cmd.scan_free ? tail_ff : head_ff;
            left_ff       <= cmd.scan_free ? DEPTH_CNT : lookup_len;
            pend_valid_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            if (left_ff != '0) begin
               issue_addr_ff <= next_slot(issue_addr_ff);
               left_ff       <= left_ff - 1'b1;
               pend_valid_ff <= 1'b1;
            end else begin
               pend_valid_ff <= 1'b0;
            end
         end
         if (cmd.commit_add) begin
            count_ff <= count_ff + 1'b1;
            tail_ff  <= next_slot(pend_addr_ff);
         end else if (cmd.commit_remove) begin
            count_ff <= count_ff - 1'b1;
            if (slot_addr == head_ff) begin
               head_ff <= next_slot(head_ff);
            end
         end
      end
   end

   // transaction payload, no reset
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         blk_ff       <= req_block_addr;
         full_ff      <= req_byte_addr;
         scan_free_ff <= cmd.scan_free;
      end
      if (cmd.scan_step) begin
         pend_addr_ff <= issue_addr_ff;
      end
      if (cmd.respond) begin
         rsp_status_ff <= cmd.resp_status;
         rsp_index_ff  <= cmd.resp_hit ? hit_ext[INDEX_W-1:0] : '0;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_index  = rsp_index_ff;

endmodule

[hdl/holey_ring_queue_with_match.sv]
// Top level of the holey ring request queue with address match.
`timescale 1ns / 1ps
//
// Usage:
//  Request channel: drive req_* and raise start; the transaction is taken at an
//  edge where start is high and busy is low. req_mode selects lookup, add or remove.
//  Response channel: one transaction per request, shown on rsp_status/rsp_index for
//  exactly one cycle with rsp_valid high. The receiver cannot stall; it must take it.
//  Config: csr_wr_en/csr_wr_data set the full-address match select; write while idle.
//  Answer timing: remove, refused adds, empty lookups and unused modes answer in
//  the cycle after acceptance without raising busy. Lookup and add walk the slot
//  memory one entry per cycle through its registered read port, up to QUEUE_DEPTH
//  entries (occupied span for lookup, whole ring for add). The response shows in
//  the first cycle busy is low again, where the next transaction may be taken.
//  Reset: after a synchronous reset the block runs a clearing pass over the slot
//  memory, one slot per cycle, with busy high; config writes are still taken
//  during it.

module holey_ring_queue_with_match import hrq_pkg::*; #(
   parameter int QUEUE_DEPTH = HRQ_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_mode,
   input  logic [ADDR_W-1:0]  req_block_addr,
   input  logic [ADDR_W-1:0]  req_byte_addr,
   input  logic [SLOT_W-1:0]  req_slot,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [INDEX_W-1:0] rsp_index,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   hrq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   hrq_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_block_addr (req_block_addr),
      .req_byte_addr  (req_byte_addr),
      .req_slot       (req_slot),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_index      (rsp_index)
   );

   // an accepted transaction either answers next cycle or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid || busy)
      else $error("accepted transaction neither answered nor started a scan");

   // failure statuses never carry a slot index
   a_fail_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_index == '0)
      else $error("nonzero index on a failed response");

   // clearing pass follows reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> busy && !rsp_valid)
      else $error("block not busy clearing after reset");

   // a scan never overlaps a response in the same cycle it is still running
   a_no_rsp_while_scan: assert property (@(posedge clock) disable iff (reset)
      busy && $past(busy) && !$past(reset) |-> !rsp_valid)
      else $error("response shown while the scan is still running");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the holey ring request queue with address match.
`timescale 1ns / 1ps

module tb_top;
   import hrq_pkg::*;

   localparam int QUEUE_DEPTH = HRQ_DEPTH_DEFAULT;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int QUIET_LIMIT = 2000;

   typedef struct packed {
      logic [1:0]         status;
      logic [INDEX_W-1:0] index;
   } answer_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_mode;
   logic [ADDR_W-1:0]  req_block_addr;
   logic [ADDR_W-1:0]  req_byte_addr;
   logic [SLOT_W-1:0]  req_slot;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic [INDEX_W-1:0] rsp_index;
   logic               csr_wr_en;
   logic               csr_wr_data;

   // shadow copy of the queue
   logic [ADDR_W-1:0] q_blk [QUEUE_DEPTH];
   logic [ADDR_W-1:0] q_full [QUEUE_DEPTH];
   int                q_head;
   int                q_tail;
   int                q_count;
   bit                match_full;

   answer_type pending_answers[$];
   int         err_count;
   int         quiet_cycles;
   int         idle_pct;

   holey_ring_queue_with_match #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_block_addr(req_block_addr),
      .req_byte_addr(req_byte_addr),
      .req_slot(req_slot),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_index(rsp_index),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      err_count++;
   endtask

   // Computes the answer to one request and updates the shadow queue.
   function automatic answer_type predict_answer(input logic [1:0] mode,
                                                 input logic [ADDR_W-1:0] blk,
                                                 input logic [ADDR_W-1:0] full,
                                                 input logic [SLOT_W-1:0] slot);
      answer_type a;
      int         s;
      int         k;
      int         span;
      int         checked;
      bit         hit;
      a.status = ST_MISS;
      a.index  = '0;
      case (mode)
         MODE_LOOKUP: begin
            if (!(q_count == 0 && q_head == q_tail)) begin
               // head == tail with entries present scans the whole ring
               span = (q_head < q_tail) ? q_tail - q_head : QUEUE_DEPTH - q_head + q_tail;
               s = q_head;
               k = 0;
               hit = 0;
               while (k < span && !hit) begin
                  hit = match_full ? (q_full[s] == full) : (q_blk[s] == blk);
                  if (!hit) begin
                     s = (s + 1) % QUEUE_DEPTH;
                     k++;
                  end
               end
               if (hit) begin
                  a.status = ST_OK;
                  a.index  = INDEX_W'(s);
               end
            end
         end
         MODE_ADD: begin
            s = q_tail;
            checked = 0;
            while (checked < QUEUE_DEPTH && q_blk[s] != '0) begin
               s = (s + 1) % QUEUE_DEPTH;
               checked++;
            end
            if ((q_count != 0 && q_head == q_tail) || q_count >= QUEUE_DEPTH ||
                checked >= QUEUE_DEPTH) begin
               a.status = ST_FULL;
            end else begin
               q_blk[s]  = blk;
               q_full[s] = full;
               q_count++;
               q_tail    = (s + 1) % QUEUE_DEPTH;
               a.status  = ST_OK;
               a.index   = INDEX_W'(s);
            end
         end
         MODE_REMOVE: begin
            if (q_count == 0) begin
               a.status = ST_EMPTY;
            end else begin
               q_blk[slot]  = '0;
               q_full[slot] = '0;
               q_count--;
               if (int'(slot) == q_head) q_head = (q_head + 1) % QUEUE_DEPTH;
               a.status = ST_OK;
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   function automatic logic [ADDR_W-1:0] pick_addr();
      int r;
      r = $urandom_range(99);
      if (r < 5) return '0;
      if (r < 10) return '1;
      if (r < 45) return ADDR_W'($urandom_range(1, 8));
      return {$urandom, $urandom};
   endfunction

   // Random slot holding a nonzero block address, or -1 if none.
   function automatic int pick_used_slot();
      int used[$];
      for (int i = 0; i < QUEUE_DEPTH; i++)
         if (q_blk[i] != '0) used.push_back(i);
      if (used.size() == 0) return -1;
      return used[$urandom_range(used.size() - 1)];
   endfunction

   // Called after a rising edge; returns at or after the edge that takes the request.
   task automatic send_req(input logic [1:0] mode, input logic [ADDR_W-1:0] blk,
                           input logic [ADDR_W-1:0] full, input logic [SLOT_W-1:0] slot);
      req_mode       <= mode;
      req_block_addr <= blk;
      req_byte_addr  <= full;
      req_slot       <= slot;
      start          <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      pending_answers.push_back(predict_answer(mode, blk, full, slot));
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   task automatic wait_quiet();
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_match_mode(input bit full_mode);
      wait_quiet();
      csr_wr_data <= full_mode;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      match_full = full_mode;
   endtask

   task automatic do_reset();
      reset <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         q_blk[i]  = '0;
         q_full[i] = '0;
      end
      q_head     = 0;
      q_tail     = 0;
      q_count    = 0;
      match_full = 0;
   endtask

   task automatic test_empty_queue();
      // written while the clearing pass runs
      set_match_mode(1'b0);
      send_req(MODE_LOOKUP, '0, '0, '0);
      send_req(MODE_REMOVE, '1, '1, '0);
      send_req(MODE_UNUSED, '1, '1, '1);
   endtask

   task automatic test_add_and_lookup();
      send_req(MODE_ADD, '1, '1, '1);
      // zero block address: counted, yet still free to later adds
      send_req(MODE_ADD, '0, 64'h8000_0000_0000_0001, '0);
      send_req(MODE_ADD, 64'd1, '0, 6'd17);
      send_req(MODE_ADD, '1, 64'd5, '0);
      send_req(MODE_LOOKUP, '1, '0, '0);
      send_req(MODE_LOOKUP, '0, '1, '1);
      send_req(MODE_LOOKUP, 64'd2, 64'd5, '0);
      send_req(MODE_ADD, 64'h0000_0001_0000_0000, 64'hdead_beef_0000_0000, '0);
   endtask

   task automatic test_byte_address_match();
      set_match_mode(1'b1);
      send_req(MODE_LOOKUP, '1, '0, '0);
      send_req(MODE_LOOKUP, '0, '1, '0);
      send_req(MODE_LOOKUP, 64'd7, 64'd5, '0);
      send_req(MODE_LOOKUP, '1, 64'd6, '0);
   endtask

   task automatic test_remove();
      send_req(MODE_REMOVE, '0, '0, 6'd0);
      send_req(MODE_REMOVE, '0, '0, 6'd40);
      send_req(MODE_REMOVE, '1, '1, 6'd63);
      send_req(MODE_LOOKUP, '1, '0, '0);
   endtask

   task automatic test_random_traffic(input int n_items, input int pct, input bit full_mode);
      int          r;
      int          used;
      bit          filling;
      logic [1:0]  mode;
      logic [ADDR_W-1:0] blk;
      logic [ADDR_W-1:0] full;
      logic [SLOT_W-1:0] slot;
      set_match_mode(full_mode);
      idle_pct = pct;
      filling  = 1'b1;
      for (int i = 0; i < n_items; i++) begin
         // every 48 items, pick at random between filling up the ring and draining it
         if (i % 48 == 0) filling = 1'($urandom_range(1));
         blk  = pick_addr();
         full = pick_addr();
         slot = SLOT_W'($urandom_range(QUEUE_DEPTH - 1));
         r    = $urandom_range(99);
         if (r < (filling ? 65 : 15)) mode = MODE_ADD;
         else if (r < 75) mode = MODE_REMOVE;
         else if (r < 97) mode = MODE_LOOKUP;
         else mode = MODE_UNUSED;
         used = pick_used_slot();
         r    = $urandom_range(99);
         if (mode == MODE_REMOVE) begin
            if (r < 50) slot = SLOT_W'(q_head);
            else if (r < 85 && used >= 0) slot = SLOT_W'(used);
         end else if (mode == MODE_LOOKUP) begin
            if (r < 55 && used >= 0) begin
               blk  = q_blk[used];
               full = q_full[used];
            end else if (r < 65) begin
               blk  = '0;
               full = '0;
            end
         end
         send_req(mode, blk, full, slot);
      end
   endtask

   // response checker
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (pending_answers.size() == 0) begin
            report_mismatch($sformatf("response with none pending: status %0d index %0d",
                                      rsp_status, rsp_index));
         end else begin
            want = pending_answers.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status: expected %0d, got %0d",
                                         want.status, rsp_status));
            if (rsp_index !== want.index)
               report_mismatch($sformatf("index: expected %0d, got %0d",
                                         want.index, rsp_index));
         end
      end
   end

   // watchdog: cycles with no transaction in either direction
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      start          <= 1'b0;
      req_mode       <= MODE_LOOKUP;
      req_block_addr <= '0;
      req_byte_addr  <= '0;
      req_slot       <= '0;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= 1'b0;
      err_count = 0;
      idle_pct  = 33;
      do_reset();
      test_empty_queue();
      test_add_and_lookup();
      test_byte_address_match();
      test_remove();
      test_random_traffic(540, 33, 1'b1);
      test_random_traffic(540, 59, 1'b0);
      test_random_traffic(540, 0, 1'b1);
      wait_quiet();
      repeat (QUEUE_DEPTH + 8) @(posedge clock);
      if (err_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
